// ===== rtl/core/rdpd_pkg.sv =====
// Shared types and constants of the run-length / difference plane decoder.
package rdpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int PT_W    = 17;
    localparam int RUN_W   = 7;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ENCODING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES_MODE = 2'd2;

    // Encoding bits
    localparam int ENC_DIFF_BIT = 0;
    localparam int ENC_RLE_BIT  = 1;

    // Control byte: top bit selects a repeated word
    localparam int CTRL_REPEAT_BIT = 7;

    localparam logic [WORD_W-1:0] MASK_16 = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] MASK_32 = 32'hFFFF_FFFF;

    localparam logic [1:0] COUNT_ONE = 2'd1;
    localparam logic [1:0] COUNT_TWO = 2'd2;

    typedef struct packed {
        logic [1:0]       plane_encoding;
        logic [PT_W-1:0]  point_count;
        logic             word_bytes_mode;
    } t_cfg;

    // One decoded word, repeated count times
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [RUN_W-1:0]  count;
        logic              done;
        logic              err;
        logic              clr;
    } t_cmd;

endpackage

// ===== rtl/core/rdpd_front.sv =====
// Byte parser: assembles words, tracks runs and plane position, issues commands.
module rdpd_front import rdpd_pkg::*; #(
    parameter int MAX_POINTS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_start,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    localparam int PT_MAX   = (1 << PT_W) - 1;
    localparam int LIM_CLIP = (MAX_POINTS > PT_MAX) ? PT_MAX : MAX_POINTS;
    localparam logic [PT_W-1:0] LIM_MAX = PT_W'(LIM_CLIP);

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_REPEAT,
        PH_LITERAL,
        PH_DONE
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [RUN_W-1:0]  r_rr, n_rr;
    logic [1:0]        r_bp, n_bp;
    logic [WORD_W-1:0] r_wa, n_wa;
    logic [PT_W-1:0]   r_pe, n_pe;
    logic              r_err, n_err;
    logic              r_pclr, n_pclr;

    logic              acc;
    logic [PT_W-1:0]   lim, pc1, avail;
    logic [WORD_W-1:0] mask, wa_new, word;
    logic              complete;
    logic [RUN_W-1:0]  req, k, cnt;
    logic              done_now;

    assign o_ready = !i_full;
    assign acc     = i_valid && o_ready;

    assign mask = i_cfg.word_bytes_mode ? MASK_32 : MASK_16;
    assign pc1  = (i_cfg.point_count == '0) ? PT_W'(1) : i_cfg.point_count;
    assign lim  = (pc1 > LIM_MAX) ? LIM_MAX : pc1;

    always_comb begin
        t_phase           s_phase;
        logic [RUN_W-1:0] s_rr;
        logic [1:0]       s_bp;
        logic [WORD_W-1:0] s_wa;
        logic [PT_W-1:0]  s_pe;
        logic             s_err;

        s_phase = r_phase;
        s_rr    = r_rr;
        s_bp    = r_bp;
        s_wa    = r_wa;
        s_pe    = r_pe;
        s_err   = r_err;
        if (i_start) begin
            s_phase = PH_CTRL;
            s_rr    = '0;
            s_bp    = '0;
            s_wa    = '0;
            s_pe    = '0;
            s_err   = 1'b0;
        end

        avail    = (lim > s_pe) ? (lim - s_pe) : '0;
        wa_new   = s_wa | (WORD_W'(i_byte) << {s_bp, 3'b000});
        complete = ({1'b0, s_bp} + 3'd1) >= (i_cfg.word_bytes_mode ? 3'd4 : 3'd2);
        word     = wa_new & mask;

        n_phase  = s_phase;
        n_rr     = s_rr;
        n_bp     = s_bp;
        n_wa     = s_wa;
        n_pe     = s_pe;
        n_err    = s_err;
        req      = '0;
        k        = '0;
        cnt      = i_byte[RUN_W-1:0];
        done_now = 1'b0;

        if (s_phase != PH_DONE) begin
            if (!i_cfg.plane_encoding[ENC_RLE_BIT] || s_phase != PH_CTRL) begin
                if (complete) begin
                    n_wa = '0;
                    n_bp = '0;
                end else begin
                    n_wa = wa_new;
                    n_bp = s_bp + 2'd1;
                end
            end

            if (!i_cfg.plane_encoding[ENC_RLE_BIT]) begin
                if (complete) req = RUN_W'(1);
            end else begin
                case (s_phase)
                    PH_CTRL: begin
                        if (PT_W'(cnt) > avail) begin
                            cnt   = avail[RUN_W-1:0];
                            n_err = 1'b1;
                        end
                        if (avail == '0) begin
                            n_phase = PH_DONE;
                        end else if (i_byte[CTRL_REPEAT_BIT]) begin
                            n_rr    = cnt;
                            n_phase = PH_REPEAT;
                        end else if (cnt != '0) begin
                            n_rr    = cnt;
                            n_phase = PH_LITERAL;
                        end
                    end
                    PH_REPEAT: begin
                        if (complete) begin
                            req     = s_rr;
                            n_rr    = '0;
                            n_phase = PH_CTRL;
                        end
                    end
                    PH_LITERAL: begin
                        if (complete) begin
                            req = RUN_W'(1);
                            if (s_rr != '0) n_rr = s_rr - RUN_W'(1);
                            if (s_rr <= RUN_W'(1)) n_phase = PH_CTRL;
                        end
                    end
                    default: ;
                endcase
            end

            // Emit the requested words, stopping at the plane limit
            if (req != '0) begin
                if (avail == '0) begin
                    n_err   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    done_now = PT_W'(req) >= avail;
                    k        = done_now ? avail[RUN_W-1:0] : req;
                    n_pe     = s_pe + PT_W'(k);
                    if (done_now) n_phase = PH_DONE;
                end
            end
        end
    end

    assign o_push       = acc && (k != '0);
    assign o_cmd.word   = word;
    assign o_cmd.count  = k;
    assign o_cmd.done   = done_now;
    assign o_cmd.err    = n_err;
    assign o_cmd.clr    = r_pclr || i_start;

    always_comb begin
        n_pclr = r_pclr;
        if (acc) begin
            if (o_push) n_pclr = 1'b0;
            else if (i_start) n_pclr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CTRL;
            r_rr    <= '0;
            r_bp    <= '0;
            r_wa    <= '0;
            r_pe    <= '0;
            r_err   <= 1'b0;
            r_pclr  <= 1'b0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_rr    <= n_rr;
            r_bp    <= n_bp;
            r_wa    <= n_wa;
            r_pe    <= n_pe;
            r_err   <= n_err;
            r_pclr  <= n_pclr;
        end
    end

endmodule

// ===== rtl/core/rdpd_cmd_fifo.sv =====
// Short command queue between the byte parser and the word expander.
module rdpd_cmd_fifo import rdpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [FIFO_PTR_W:0]   r_cnt;
    logic                  do_push, do_pop;

    assign o_full  = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + FIFO_PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + FIFO_PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (FIFO_PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (FIFO_PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/rdpd_back.sv =====
// Word expander: turns commands into results of up to two words, applying differences.
module rdpd_back import rdpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_first,
    output logic [WORD_W-1:0] o_second,
    output logic [1:0]        o_count,
    output logic              o_done,
    output logic              o_err
);

    logic              r_busy;
    logic [WORD_W-1:0] r_word, r_w2, r_prev;
    logic [RUN_W-1:0]  r_left;
    logic              r_done, r_err;

    logic [WORD_W-1:0] mask, sum1, sum2, v1, v2;
    logic              diff, two, last, step;

    assign mask = i_cfg.word_bytes_mode ? MASK_32 : MASK_16;
    assign diff = i_cfg.plane_encoding[ENC_DIFF_BIT];
    assign sum1 = (r_prev + r_word) & mask;
    assign sum2 = (r_prev + r_w2) & mask;
    assign v1   = diff ? sum1 : r_word;
    assign v2   = diff ? sum2 : r_word;
    assign two  = r_left >= RUN_W'(2);
    assign last = r_left <= RUN_W'(2);
    assign step = r_busy && (!o_valid || i_ready);
    assign o_pop = !r_busy && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_prev  <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                if (i_cmd.clr) r_prev <= '0;
            end else if (step) begin
                r_prev <= two ? v2 : v1;
                if (last) r_busy <= 1'b0;
            end
            if (step) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // Payload: hold the command and the result under way
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_cmd.word;
            r_w2   <= {i_cmd.word[WORD_W-2:0], 1'b0};
            r_left <= i_cmd.count;
            r_done <= i_cmd.done;
            r_err  <= i_cmd.err;
        end else if (step) begin
            r_left <= two ? (r_left - RUN_W'(2)) : (r_left - RUN_W'(1));
        end
        if (step) begin
            o_first  <= v1;
            o_second <= two ? v2 : '0;
            o_count  <= two ? COUNT_TWO : COUNT_ONE;
            o_done   <= r_done && last;
            o_err    <= r_err;
        end
    end

endmodule

// ===== rtl/core/rle_delta_plane_decoder_top.sv =====
// Top level of the run-length / difference plane decoder: configuration and wiring.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready| tdata: data_byte; tuser: plane_start
//  m       | out | o_m_tvalid/i_m_tready| tdata: first, second, count; tlast; tuser
//  cfg     | in  | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while the four-entry command queue has room.
// Each decoded word group becomes one command; the expander loads it and then
// gives its words as results of up to two words each, so a repeat run of n
// words holds the input once the queue fills behind it.
// Reset is synchronous and clears all control state; there is no clearing pass.
// A stalled output holds its result while the parser keeps filling the queue.
module rle_delta_plane_decoder_top import rdpd_pkg::*; #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] data_byte
    input  logic                   i_s_tuser,   // [0] plane_start
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [31:0] first_value, [63:32] second_value,
                                                // [65:64] value_count, [71:66] zero
    output logic                   o_m_tlast,   // plane_done
    output logic                   o_m_tuser,   // [0] overrun_error
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg              r_cfg;
    logic              push, pop, full, empty;
    t_cmd              cmd_in, cmd_out;
    logic [WORD_W-1:0] first_v, second_v;
    logic [1:0]        count_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_encoding  <= '0;
            r_cfg.point_count     <= PT_W'(1);
            r_cfg.word_bytes_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PLANE_ENCODING:  r_cfg.plane_encoding  <= i_cfg_data[1:0];
                CFG_POINT_COUNT:     r_cfg.point_count     <= i_cfg_data[PT_W-1:0];
                CFG_WORD_BYTES_MODE: r_cfg.word_bytes_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rdpd_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata[BYTE_W-1:0]),
        .i_start (i_s_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    rdpd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_full  (full),
        .o_empty (empty)
    );

    rdpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_cmd    (cmd_out),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_first  (first_v),
        .o_second (second_v),
        .o_count  (count_v),
        .o_done   (o_m_tlast),
        .o_err    (o_m_tuser)
    );

    assign o_m_tdata = {6'b0, count_v, second_v, first_v};

endmodule

// ===== rtl/core/rdpd_checker.sv =====
// Port-level checks on the plane decoder, bound to its top level.
module rdpd_checker import rdpd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tlast,
    input logic                   o_m_tuser
);

    // Hold a stalled result unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[65:64] == COUNT_ONE) || (o_m_tdata[65:64] == COUNT_TWO))
        else $error("result carries no word count of one or two");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[65:64] == COUNT_ONE) |-> (o_m_tdata[63:32] == '0))
        else $error("second word not cleared on a single-word result");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered straight after reset");

endmodule

bind rle_delta_plane_decoder_top rdpd_checker u_rdpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/rle_delta_plane_decoder_top_test.sv =====
// Self-checking testbench for the run-length / difference plane decoder top level.
module rle_delta_plane_decoder_top_test;
    import rdpd_pkg::*;

    localparam int PLANE_MAX    = 65536;
    localparam int ITEMS_TARGET = 500;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 8_000_000;

    typedef enum logic [1:0] {
        AWAIT_CTRL,
        REPEAT_RUN,
        LITERAL_RUN,
        PLANE_FINISHED
    } t_decode_phase;

    typedef struct packed {
        logic [WORD_W-1:0] first;
        logic [WORD_W-1:0] second;
        logic [1:0]        count;
        logic              done;
        logic              err;
    } t_plane_result;

    // Shadow decoder: mirrors registers and plane state, queues the results each byte causes
    class plane_decoder_shadow;
        logic [1:0]        enc;
        logic [PT_W-1:0]   pts;
        logic              wide;
        t_decode_phase     phase;
        logic [RUN_W-1:0]  run_left;
        logic [1:0]        byte_pos;
        logic [WORD_W-1:0] assembly;
        logic [PT_W-1:0]   emitted;
        logic [WORD_W-1:0] prev;
        logic              err;
        logic [WORD_W-1:0] words[$];
        bit                done_now;
        t_plane_result     pending[$];
        int                mismatches;
        int                results_seen;

        function new();
            enc = 2'd0;
            pts = PT_W'(1);
            wide = 1'b0;
            mismatches = 0;
            results_seen = 0;
            clear_plane();
        endfunction

        function void clear_plane();
            phase = AWAIT_CTRL;
            run_left = '0;
            byte_pos = '0;
            assembly = '0;
            emitted = '0;
            prev = '0;
            err = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
            case (idx)
                CFG_PLANE_ENCODING:  enc = val[1:0];
                CFG_POINT_COUNT:     pts = val[PT_W-1:0];
                CFG_WORD_BYTES_MODE: wide = val[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function logic [WORD_W-1:0] word_mask();
            return wide ? MASK_32 : MASK_16;
        endfunction

        function int unsigned plane_limit();
            int unsigned p;
            p = pts;
            if (p == 0) p = 1;
            if (p > PLANE_MAX) p = PLANE_MAX;
            return p;
        endfunction

        // Add a byte to the word under assembly; true once the word is complete
        function bit gather_byte(logic [7:0] b, output logic [WORD_W-1:0] w);
            int nb;
            nb = wide ? 4 : 2;
            w = '0;
            assembly = assembly | ({24'd0, b} << (8 * byte_pos));
            if (int'(byte_pos) + 1 >= nb) begin
                w = assembly & word_mask();
                assembly = '0;
                byte_pos = '0;
                return 1'b1;
            end
            byte_pos = byte_pos + 2'd1;
            return 1'b0;
        endfunction

        function void emit_word(logic [WORD_W-1:0] w);
            logic [WORD_W-1:0] v;
            if (phase == PLANE_FINISHED || words.size() >= 128) return;
            // a lowered point count drops the word and stops the plane
            if (emitted >= plane_limit()) begin
                err = 1'b1;
                phase = PLANE_FINISHED;
                return;
            end
            if (enc[ENC_DIFF_BIT]) v = (prev + w) & word_mask();
            else v = w & word_mask();
            prev = v;
            words.push_back(v);
            emitted = emitted + 1'b1;
            if (emitted >= plane_limit()) begin
                phase = PLANE_FINISHED;
                done_now = 1'b1;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic ps);
            logic [WORD_W-1:0] w;
            int unsigned cnt, lim, rem;
            int nres, a;
            t_plane_result r;
            words.delete();
            done_now = 1'b0;
            if (ps) clear_plane();
            if (phase == PLANE_FINISHED) return;
            if (!enc[ENC_RLE_BIT]) begin
                if (gather_byte(b, w)) emit_word(w);
            end else if (phase == AWAIT_CTRL) begin
                cnt = b[6:0];
                lim = plane_limit();
                rem = (lim > emitted) ? lim - emitted : 0;
                // cut an over-long run to what is left of the plane
                if (cnt > rem) begin
                    cnt = rem;
                    err = 1'b1;
                end
                if (rem == 0) begin
                    phase = PLANE_FINISHED;
                end else if (b[CTRL_REPEAT_BIT]) begin
                    run_left = cnt[RUN_W-1:0];
                    phase = REPEAT_RUN;
                end else if (cnt != 0) begin
                    run_left = cnt[RUN_W-1:0];
                    phase = LITERAL_RUN;
                end
            end else if (phase == REPEAT_RUN) begin
                if (gather_byte(b, w)) begin
                    for (int i = 0; i < int'(run_left); i++) emit_word(w);
                    run_left = '0;
                    if (phase != PLANE_FINISHED) phase = AWAIT_CTRL;
                end
            end else begin
                if (gather_byte(b, w)) begin
                    emit_word(w);
                    if (run_left > 0) run_left = run_left - 1'b1;
                    if (run_left == 0 && phase != PLANE_FINISHED) phase = AWAIT_CTRL;
                end
            end
            nres = (words.size() + 1) / 2;
            for (int k = 0; k < nres; k++) begin
                a = 2 * k;
                r.first = words[a];
                r.second = (a + 1 < words.size()) ? words[a + 1] : '0;
                r.count = (a + 1 < words.size()) ? COUNT_TWO : COUNT_ONE;
                r.done = done_now && (k == nres - 1);
                r.err = err;
                pending.push_back(r);
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast, logic tuser);
            t_plane_result want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: tdata %h tlast %b tuser %b",
                         $time, tdata, tlast, tuser);
                return;
            end
            want = pending.pop_front();
            if (tdata[31:0] !== want.first) begin
                mismatches++;
                $display("%0t: first_value expected %h actual %h", $time, want.first,
                         tdata[31:0]);
            end
            if (tdata[63:32] !== want.second) begin
                mismatches++;
                $display("%0t: second_value expected %h actual %h", $time, want.second,
                         tdata[63:32]);
            end
            if (tdata[65:64] !== want.count) begin
                mismatches++;
                $display("%0t: value_count expected %0d actual %0d", $time, want.count,
                         tdata[65:64]);
            end
            if (tlast !== want.done) begin
                mismatches++;
                $display("%0t: plane_done expected %b actual %b", $time, want.done, tlast);
            end
            if (tuser !== want.err) begin
                mismatches++;
                $display("%0t: overrun_error expected %b actual %b", $time, want.err, tuser);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tuser;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]       i_cfg_data;

    plane_decoder_shadow shadow;
    bit calm;
    int stall_left = 0;
    int cycles = 0;
    int bytes_sent;
    int planes_started;
    int reg_writes;
    int phase_no;

    rle_delta_plane_decoder_top #(.MAX_POINTS(PLANE_MAX)) dut (.*);

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 6) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            shadow.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
    end

    function automatic logic [7:0] word_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int run_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 20) return 127;
        if (r < 28) return $urandom_range(13, 126);
        return $urandom_range(1, 6);
    endfunction

    function automatic int unsigned pick_points();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return $urandom_range(1, 8);
        if (r < 70) return $urandom_range(9, 64);
        if (r < 85) return $urandom_range(65, 300);
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return PLANE_MAX;
            2:       return 17'h1FFFF;
            default: return PLANE_MAX + 1;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val[CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        shadow.write_reg(idx, val);
        reg_writes++;
    endtask

    // Hold off until every expected result is out and the parser has gone quiet
    task automatic settle();
        i_s_tvalid = 1'b0;
        while (shadow.outstanding() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic ps);
        int gap;
        gap = calm ? 0 : sender_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = b;
        i_s_tuser = ps;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        shadow.note_byte(b, ps);
        bytes_sent++;
        if (ps) planes_started++;
        @(negedge i_clk);
    endtask

    // Mostly well-formed runs for the current settings, with some stray bytes and restarts
    task automatic feed_stream(input int budget, input bit fresh);
        int start, nb, cnt, nbytes, i;
        bit ps, rep;
        start = bytes_sent;
        ps = fresh;
        while (bytes_sent - start < budget) begin
            nb = shadow.wide ? 4 : 2;
            if ($urandom_range(0, 19) == 0) begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                ps = 1'b0;
            end else if (shadow.enc[ENC_RLE_BIT]) begin
                cnt = run_count();
                rep = 1'($urandom_range(0, 1));
                if (!rep && cnt > 12) cnt = $urandom_range(7, 12);
                push_byte({rep, cnt[6:0]}, ps);
                ps = 1'b0;
                nbytes = rep ? nb : cnt * nb;
                for (i = 0; i < nbytes && bytes_sent - start < budget; i++)
                    push_byte(word_byte(), 1'b0);
            end else begin
                for (i = 0; i < nb && bytes_sent - start < budget; i++) begin
                    push_byte(word_byte(), ps);
                    ps = 1'b0;
                end
            end
        end
    endtask

    initial begin
        shadow = new();
        calm = 1'b0;
        bytes_sent = 0;
        planes_started = 0;
        reg_writes = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_PLANE_ENCODING;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: one 16-bit word ends the plane, the byte after it is ignored
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hAA, 1'b0);

        // Run-length: empty repeat, empty literal, then a full-length repeat cut to the plane
        settle();
        write_reg(CFG_PLANE_ENCODING, 2);
        write_reg(CFG_POINT_COUNT, 4);
        write_reg(CFG_WORD_BYTES_MODE, 0);
        push_byte(8'h80, 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h12, 1'b0);

        // Difference decoding of 32-bit literals wraps round; then leave a word half built
        settle();
        write_reg(CFG_PLANE_ENCODING, 3);
        write_reg(CFG_POINT_COUNT, PLANE_MAX);
        write_reg(CFG_WORD_BYTES_MODE, 1);
        push_byte(8'h02, 1'b1);
        repeat (4) push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b0);
        repeat (3) push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b0);

        // Narrow the word mid-assembly: the next byte completes it
        settle();
        write_reg(CFG_WORD_BYTES_MODE, 0);
        push_byte(8'h33, 1'b0);

        phase_no = 0;
        while (bytes_sent < ITEMS_TARGET) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            if (phase_no < 2) begin
                write_reg(CFG_PLANE_ENCODING, $urandom_range(0, 3));
                write_reg(CFG_POINT_COUNT, (phase_no == 0) ? 0 : 17'h1FFFF);
                write_reg(CFG_WORD_BYTES_MODE, $urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 1)) write_reg(CFG_PLANE_ENCODING, $urandom_range(0, 3));
                if ($urandom_range(0, 1)) write_reg(CFG_POINT_COUNT, pick_points());
                if ($urandom_range(0, 1)) write_reg(CFG_WORD_BYTES_MODE, $urandom_range(0, 1));
            end
            feed_stream($urandom_range(8, 50), $urandom_range(0, 4) != 0);
            phase_no++;
        end
        i_s_tvalid = 1'b0;
        calm = 1'b0;

        while (shadow.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input bytes over %0d plane starts and %0d setting phases",
                 bytes_sent, planes_started, phase_no);
        $display("checked %0d results after %0d register writes, %0d mismatches",
                 shadow.results_seen, reg_writes, shadow.mismatches);
        if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
